/* sv/gbs_pkg.sv */
package gbs_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 12;
    localparam int IDX_BITS   = $clog2(MAX_BOXES);
    localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
    localparam int SCORE_BITS = 16;
    localparam int THR_BITS   = 16;
    localparam int EXT_BITS   = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * EXT_BITS;
    localparam int UNI_BITS   = AREA_BITS + 1;
    localparam int PROD_BITS  = UNI_BITS + THR_BITS;
    localparam int QDEPTH     = 4;
    localparam int QPTR_BITS  = $clog2(QDEPTH);

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd39322;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [SCORE_BITS-1:0] score;
    } box_t;

    typedef struct packed {
        box_t box;
        logic last;
    } qitem_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_FET,
        ST_SORT_CMP,
        ST_NMS_RD,
        ST_NMS_DEC,
        ST_NMS_CMP,
        ST_NMS_CHK,
        ST_EMIT_RD,
        ST_EMIT_FET,
        ST_EMIT_OUT
    } state_t;

endpackage

/* sv/gbs_front.sv */
module gbs_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gbs_pkg::qitem_t       in_item,
    output logic                  q_valid,
    input  logic                  q_ready,
    output gbs_pkg::qitem_t       q_item
);

    gbs_pkg::qitem_t mem [gbs_pkg::QDEPTH];
    logic [gbs_pkg::QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [gbs_pkg::QPTR_BITS:0]   fill_reg;
    logic push, pop;

    assign in_ready = (fill_reg != gbs_pkg::QPTR_BITS'(0) + (gbs_pkg::QPTR_BITS+1)'(gbs_pkg::QDEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 1'b1;
                2'b01:   fill_reg <= fill_reg - 1'b1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= (gbs_pkg::QPTR_BITS+1)'(gbs_pkg::QDEPTH))
        else $error("queue fill out of range");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0) |-> !pop)
        else $error("pop from empty queue");
    a_fill_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("fill count slip");

endmodule

/* sv/gbs_iou.sv */
module gbs_iou (
    input  logic                       aclk,
    input  gbs_pkg::box_t              box_a,
    input  gbs_pkg::box_t              box_b,
    input  logic [gbs_pkg::THR_BITS-1:0] threshold,
    output logic                       hit
);
    // extents and areas are registered, then the intersection and union products, then the compare
    localparam int CB = gbs_pkg::COORD_BITS;
    localparam int EB = gbs_pkg::EXT_BITS;
    localparam int AB = gbs_pkg::AREA_BITS;
    localparam int UB = gbs_pkg::UNI_BITS;
    localparam int PB = gbs_pkg::PROD_BITS;

    logic [CB:0] lo_x, hi_x, lo_y, hi_y;
    logic [CB:0] ax_end, bx_end, ay_end, by_end;
    logic [EB:0] ex_x, ex_y;
    logic [EB-1:0] ex_x_reg, ex_y_reg;
    logic [AB-1:0] area_a_reg, area_b_reg;
    logic [AB-1:0] inter;
    logic [UB-1:0] uni;

    always_comb begin
        ax_end = {1'b0, box_a.x} + {1'b0, box_a.w};
        bx_end = {1'b0, box_b.x} + {1'b0, box_b.w};
        ay_end = {1'b0, box_a.y} + {1'b0, box_a.h};
        by_end = {1'b0, box_b.y} + {1'b0, box_b.h};
        lo_x = (box_a.x > box_b.x) ? {1'b0, box_a.x} : {1'b0, box_b.x};
        lo_y = (box_a.y > box_b.y) ? {1'b0, box_a.y} : {1'b0, box_b.y};
        hi_x = (ax_end < bx_end) ? ax_end : bx_end;
        hi_y = (ay_end < by_end) ? ay_end : by_end;
        ex_x = ({1'b0, hi_x} + 1'b1 <= {1'b0, lo_x}) ? '0 : {1'b0, hi_x} + 1'b1 - {1'b0, lo_x};
        ex_y = ({1'b0, hi_y} + 1'b1 <= {1'b0, lo_y}) ? '0 : {1'b0, hi_y} + 1'b1 - {1'b0, lo_y};
    end

    always_ff @(posedge aclk) begin
        ex_x_reg   <= ex_x[EB-1:0];
        ex_y_reg   <= ex_y[EB-1:0];
        area_a_reg <= ({1'b0, box_a.w} + 1'b1) * ({1'b0, box_a.h} + 1'b1);
        area_b_reg <= ({1'b0, box_b.w} + 1'b1) * ({1'b0, box_b.h} + 1'b1);
    end

    logic [AB-1:0] inter_reg;
    logic [UB-1:0] uni_reg;
    assign inter = ex_x_reg * ex_y_reg;
    assign uni   = {1'b0, area_a_reg} + {1'b0, area_b_reg} - {1'b0, inter};

    always_ff @(posedge aclk) begin
        inter_reg <= inter;
        uni_reg   <= uni;
    end

    always_ff @(posedge aclk) begin
        hit <= ({inter_reg, 16'b0} >= PB'(threshold * uni_reg));
    end
endmodule

/* sv/gbs_core.sv */
module gbs_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  gbs_pkg::qitem_t             q_item,
    input  logic [gbs_pkg::THR_BITS-1:0] threshold,
    output logic                        m_valid,
    input  logic                        m_ready,
    output gbs_pkg::box_t               m_box,
    output logic                        m_last,
    output logic                        m_ovf
);
    localparam int IB = gbs_pkg::IDX_BITS;
    localparam int NB = gbs_pkg::CNT_BITS;
    localparam int N  = gbs_pkg::MAX_BOXES;
    localparam int IOU_LAT = 3;

    gbs_pkg::box_t store [N];
    logic [IB-1:0] order_mem [N];
    logic [N-1:0]  supp_reg, supp_next;

    gbs_pkg::state_t state_reg, state_next;
    logic [NB-1:0] count_reg, count_next;
    logic [NB-1:0] i_reg, i_next, j_reg, j_next;
    logic [NB-1:0] last_reg, last_next;
    logic [1:0]    wait_reg, wait_next;
    logic          ovf_reg, ovf_next;
    logic          wr_en;
    logic [IB-1:0] rd_a_addr, rd_b_addr;
    gbs_pkg::box_t box_a_reg, box_b_reg;
    logic          hit;
    logic          ord_we;
    logic [IB-1:0] ord_waddr, ord_wdata, ord_ra, ord_rb;
    logic [IB-1:0] oa_reg, ob_reg;
    logic          out_valid_reg, out_load;
    gbs_pkg::box_t out_box_reg;
    logic          out_last_reg, out_ovf_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) store[count_reg[IB-1:0]] <= q_item.box;
        box_a_reg <= store[rd_a_addr];
        box_b_reg <= store[rd_b_addr];
    end

    // order list: store indexes in score order; one write, two registered reads
    always_ff @(posedge aclk) begin
        if (ord_we) order_mem[ord_waddr] <= ord_wdata;
        oa_reg <= order_mem[ord_ra];
        ob_reg <= order_mem[ord_rb];
    end

    gbs_iou u_iou (
        .aclk(aclk), .box_a(box_a_reg), .box_b(box_b_reg),
        .threshold(threshold), .hit(hit)
    );

    // sort: order[0..i-1] sorted; j walks down while order[j-1] score < new score
    // suppression: i walks the order, j the later entries; last_reg keeps the
    // position of the last survivor seen
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        last_next  = last_reg;
        wait_next  = wait_reg;
        ovf_next   = ovf_reg;
        supp_next  = supp_reg;
        q_ready    = 1'b0;
        wr_en      = 1'b0;
        ord_we     = 1'b0;
        ord_waddr  = j_reg[IB-1:0];
        ord_wdata  = i_reg[IB-1:0];
        ord_ra     = i_reg[IB-1:0];
        ord_rb     = j_reg[IB-1:0];
        out_load   = 1'b0;
        rd_a_addr  = oa_reg;
        rd_b_addr  = ob_reg;
        case (state_reg)
            gbs_pkg::ST_LOAD: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (count_reg < NB'(N)) begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (q_item.last) begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = gbs_pkg::ST_SORT_RD;
                    end
                end
            end
            gbs_pkg::ST_SORT_RD: begin
                if (i_reg == count_reg) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = gbs_pkg::ST_NMS_RD;
                end else if (j_reg == '0) begin
                    ord_we = 1'b1;
                    i_next = i_reg + 1'b1;
                    j_next = i_reg + 1'b1;
                end else begin
                    ord_rb     = j_reg[IB-1:0] - 1'b1;
                    state_next = gbs_pkg::ST_SORT_FET;
                end
            end
            gbs_pkg::ST_SORT_FET: begin
                ord_rb     = j_reg[IB-1:0] - 1'b1;
                rd_a_addr  = i_reg[IB-1:0];
                state_next = gbs_pkg::ST_SORT_CMP;
            end
            gbs_pkg::ST_SORT_CMP: begin
                ord_we = 1'b1;
                if (box_b_reg.score < box_a_reg.score) begin
                    ord_wdata = ob_reg;
                    j_next    = j_reg - 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                    j_next = i_reg + 1'b1;
                end
                state_next = gbs_pkg::ST_SORT_RD;
            end
            gbs_pkg::ST_NMS_RD: begin
                if (i_reg == count_reg) begin
                    i_next     = '0;
                    state_next = gbs_pkg::ST_EMIT_RD;
                end else begin
                    state_next = gbs_pkg::ST_NMS_DEC;
                end
            end
            gbs_pkg::ST_NMS_DEC: begin
                if (supp_reg[oa_reg] || j_reg >= count_reg || j_reg <= i_reg) begin
                    if (j_reg <= i_reg && !supp_reg[oa_reg]) begin
                        last_next = i_reg;
                    end
                    if (j_reg <= i_reg && !supp_reg[oa_reg] && i_reg + 1'b1 < count_reg) begin
                        j_next = i_reg + 1'b1;
                    end else begin
                        i_next = i_reg + 1'b1;
                        j_next = '0;
                    end
                    state_next = gbs_pkg::ST_NMS_RD;
                end else if (supp_reg[ob_reg]) begin
                    j_next     = j_reg + 1'b1;
                    state_next = gbs_pkg::ST_NMS_RD;
                end else begin
                    wait_next  = 2'(IOU_LAT);
                    state_next = gbs_pkg::ST_NMS_CMP;
                end
            end
            gbs_pkg::ST_NMS_CMP: begin
                wait_next = wait_reg - 1'b1;
                if (wait_reg == 2'd1) state_next = gbs_pkg::ST_NMS_CHK;
            end
            gbs_pkg::ST_NMS_CHK: begin
                if (hit) supp_next[ob_reg] = 1'b1;
                j_next     = j_reg + 1'b1;
                state_next = gbs_pkg::ST_NMS_RD;
            end
            gbs_pkg::ST_EMIT_RD: begin
                if (i_reg == count_reg) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    supp_next  = '0;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = gbs_pkg::ST_LOAD;
                end else begin
                    state_next = gbs_pkg::ST_EMIT_FET;
                end
            end
            gbs_pkg::ST_EMIT_FET: begin
                if (supp_reg[oa_reg]) begin
                    i_next     = i_reg + 1'b1;
                    state_next = gbs_pkg::ST_EMIT_RD;
                end else begin
                    state_next = gbs_pkg::ST_EMIT_OUT;
                end
            end
            gbs_pkg::ST_EMIT_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = gbs_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = gbs_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbs_pkg::ST_LOAD;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            last_reg  <= '0;
            wait_reg  <= '0;
            ovf_reg   <= 1'b0;
            supp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            last_reg  <= last_next;
            wait_reg  <= wait_next;
            ovf_reg   <= ovf_next;
            supp_reg  <= supp_next;
        end
    end

    // output register: box comes from read port a, fetched in the emit fetch state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_box_reg  <= box_a_reg;
            out_last_reg <= (i_reg == last_reg);
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_box   = out_box_reg;
    assign m_last  = out_last_reg;
    assign m_ovf   = out_ovf_reg;

    a_load_only: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == gbs_pkg::ST_LOAD)
        else $error("queue drained outside load");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NB'(N))
        else $error("box count beyond capacity");
    a_supp_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gbs_pkg::ST_LOAD) |-> supp_reg == '0)
        else $error("suppression flags left set");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg && $stable(out_box_reg))
        else $error("result changed while waiting");

endmodule

/* sv/greedy_box_suppression.sv */
// channel   dir  handshake              payload
// s_axis    in   s_tvalid/s_tready      tdata box, tlast last_box
// m_axis    out  m_tvalid/m_tready      tdata kept box, tlast last_kept, tuser overflow
// apb       in   psel/penable/pwrite    reg 0 overlap_threshold @ 0x0
//
// Loading passes boxes through a four-entry queue.
// Sort is insertion, about N*N/2 compares worst case.
// Suppression: order read, decide, three-stage overlap unit and check per live pair, order
// read and decide per skipped pair. Emission: read and fetch per stored box, output per survivor.
// Reset (aresetn low, synchronous) empties queue, count, flags and output.
// Output stalls hold the emit walk; input stalls only while the queue is full.
module greedy_box_suppression (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x[11:0] y[23:12] width[35:24] height[47:36] score[63:48]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // x[11:0] y[23:12] width[35:24] height[47:36] score[63:48]
    output logic        m_tlast,
    output logic        m_tuser,   // overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CB = gbs_pkg::COORD_BITS;

    logic [gbs_pkg::THR_BITS-1:0] thr_reg;
    gbs_pkg::qitem_t in_item, q_item;
    gbs_pkg::box_t   m_box;
    logic            q_valid, q_ready;

    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= gbs_pkg::THR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == gbs_pkg::REG_THRESHOLD
                     && paddr[1:0] == 2'b00) begin
            thr_reg <= pwdata[gbs_pkg::THR_BITS-1:0];
        end
    end
    assign prdata = (paddr[2] == gbs_pkg::REG_THRESHOLD) ? {16'b0, thr_reg} : 32'b0;

    assign in_item.box.x     = s_tdata[CB-1:0];
    assign in_item.box.y     = s_tdata[2*CB-1:CB];
    assign in_item.box.w     = s_tdata[3*CB-1:2*CB];
    assign in_item.box.h     = s_tdata[4*CB-1:3*CB];
    assign in_item.box.score = s_tdata[63:48];
    assign in_item.last      = s_tlast;

    gbs_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    gbs_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .threshold(thr_reg),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_box(m_box),
        .m_last(m_tlast), .m_ovf(m_tuser)
    );

    assign m_tdata = {m_box.score, m_box.h, m_box.w, m_box.y, m_box.x};
endmodule

/* bench/gbs_checker.sv */
`timescale 1ns / 1ps

module gbs_checker
    import gbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          kept_pending
);

    typedef struct {
        box_t box;
        logic last;
        logic ovf;
    } kept_t;

    box_t                set_boxes[$];
    logic                set_ovf;
    logic [THR_BITS-1:0] thr;
    kept_t               kept_q[$];

    function automatic box_t unpack_box(logic [63:0] d);
        box_t b;
        b.x     = d[11:0];
        b.y     = d[23:12];
        b.w     = d[35:24];
        b.h     = d[47:36];
        b.score = d[63:48];
        return b;
    endfunction

    // plus-one pixel extent of the overlap on one axis
    function automatic longint unsigned span(int unsigned lo_a, int unsigned len_a,
                                             int unsigned lo_b, int unsigned len_b);
        int unsigned lo, hi;
        lo = (lo_a > lo_b) ? lo_a : lo_b;
        hi = (lo_a + len_a < lo_b + len_b) ? lo_a + len_a : lo_b + len_b;
        if (hi + 1 <= lo) return 0;
        return hi + 1 - lo;
    endfunction

    function automatic bit too_close(box_t a, box_t b, logic [THR_BITS-1:0] t);
        longint unsigned area_a, area_b, inter, uni;
        area_a = longint'(a.w + 1) * longint'(a.h + 1);
        area_b = longint'(b.w + 1) * longint'(b.h + 1);
        inter  = span(a.x, a.w, b.x, b.w) * span(a.y, a.h, b.y, b.h);
        uni    = area_a + area_b - inter;
        return inter * 65536 >= longint'(t) * uni;
    endfunction

    // sort by score (stable), greedy suppression, queue the survivors
    task automatic predict_survivors();
        int  order[MAX_BOXES];
        bit  gone[MAX_BOXES];
        int  n, i, j, cur, last_i;
        kept_t k;
        n = set_boxes.size();
        for (i = 0; i < n; i++) begin
            cur = i;
            j = i;
            while (j > 0 && set_boxes[order[j-1]].score < set_boxes[cur].score) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
            gone[i] = 0;
        end
        for (i = 0; i < n; i++) begin
            if (gone[order[i]]) continue;
            for (j = i + 1; j < n; j++)
                if (!gone[order[j]] && too_close(set_boxes[order[i]], set_boxes[order[j]], thr))
                    gone[order[j]] = 1;
        end
        last_i = 0;
        for (i = 0; i < n; i++)
            if (!gone[order[i]]) last_i = i;
        for (i = 0; i < n; i++) begin
            if (gone[order[i]]) continue;
            k.box  = set_boxes[order[i]];
            k.last = (i == last_i);
            k.ovf  = set_ovf;
            kept_q.insert(kept_q.size(), k);
        end
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    assign kept_pending = kept_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        kept_t e;
        box_t  g;
        if (!aresetn) begin
            set_boxes.delete();
            kept_q.delete();
            set_ovf = 0;
            thr     = THR_RESET;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                thr = pwdata[THR_BITS-1:0];
            if (s_tvalid && s_tready) begin
                if (set_boxes.size() < MAX_BOXES)
                    set_boxes.insert(set_boxes.size(), unpack_box(s_tdata));
                else set_ovf = 1;
                if (s_tlast) begin
                    predict_survivors();
                    set_boxes.delete();
                    set_ovf = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (kept_q.size() == 0) begin
                    report("unexpected results", 1, 0);
                end else begin
                    e = kept_q.pop_front();
                    g = unpack_box(m_tdata);
                    if (g.x != e.box.x) report("kept_x", g.x, e.box.x);
                    if (g.y != e.box.y) report("kept_y", g.y, e.box.y);
                    if (g.w != e.box.w) report("kept_width", g.w, e.box.w);
                    if (g.h != e.box.h) report("kept_height", g.h, e.box.h);
                    if (g.score != e.box.score) report("kept_score", g.score, e.box.score);
                    if (m_tlast !== e.last) report("last_kept", m_tlast, e.last);
                    if (m_tuser !== e.ovf) report("overflow", m_tuser, e.ovf);
                end
            end
        end
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import gbs_pkg::*;

    localparam int IDLE_LIMIT   = 100000; // far above a full 64-box set plus the long stall
    localparam int RANDOM_ITEMS = 360;
    localparam int HOLD_CYCLES  = 3000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int kept_pending;
    int send_idle_pct = 0;   // chance per item that the sender inserts a gap
    int recv_stall_pct = 0;  // chance per cycle that the receiver drops tready
    bit hold_go = 0;         // request one long receiver hold-off
    int items_sent = 0;
    int idle_cycles = 0;
    logic s_took = 0;        // item accepted at the last rising edge

    always #1 aclk = ~aclk;

    greedy_box_suppression u_dut (.*);

    gbs_checker u_chk (.*);

    always @(posedge aclk) s_took <= s_tvalid && s_tready;

    // watchdog: nothing moving on either channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                hold_go = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // one item out; tvalid stays high into the next item when no gap is drawn
    task automatic send_box(box_t b, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {b.score, b.h, b.w, b.y, b.x};
        s_tlast  <= last;
        do @(negedge aclk); while (!s_took);
        items_sent++;
    endtask

    function automatic box_t mk_box(int x, int y, int w, int h, int sc);
        box_t b;
        b.x = 12'(x); b.y = 12'(y); b.w = 12'(w); b.h = 12'(h); b.score = 16'(sc);
        return b;
    endfunction

    // drain all results, then give the block time to return to loading
    task automatic wait_idle();
        s_tvalid <= 0;
        s_tlast  <= 0;
        @(negedge aclk);
        while (kept_pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        wait_idle();
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'd0; pwdata <= {16'h0, v};
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge aclk);
    endtask

    // random set: mostly boxes clustered around one spot so that overlaps are common,
    // some fully random boxes, scores often drawn from a few values to make ties
    task automatic random_set(int n);
        int cx, cy, i, sc;
        box_t b;
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        for (i = 0; i < n; i++) begin
            sc = ($urandom_range(3) == 0) ? 16'h4000 * $urandom_range(3) + $urandom_range(1)
                                          : $urandom_range(65535);
            if ($urandom_range(4) == 0) begin
                b = mk_box($urandom_range(4095), $urandom_range(4095),
                           $urandom_range(4095), $urandom_range(4095), sc);
            end else begin
                b = mk_box((cx + $urandom_range(15)) % 4096, (cy + $urandom_range(15)) % 4096,
                           20 + $urandom_range(40), 20 + $urandom_range(40), sc);
            end
            send_box(b, i == n - 1);
        end
    endtask

    initial begin
        logic [15:0] thr_list[3];
        int phase, big_done, n;
        thr_list = '{16'd32768, 16'd50000, 16'd39322};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed part at the reset threshold
        send_box(mk_box(4095, 4095, 4095, 4095, 65535), 1);       // all-ones single box
        send_box(mk_box(0, 0, 0, 0, 0), 1);                       // all-zeros single box
        send_box(mk_box(10, 10, 30, 30, 500), 0);                 // equal scores: first wins
        send_box(mk_box(10, 10, 30, 30, 500), 0);
        send_box(mk_box(2000, 2000, 5, 5, 500), 0);               // disjoint tie survives
        send_box(mk_box(12, 12, 30, 30, 900), 1);                 // best comes last
        send_box(mk_box(4090, 0, 4095, 4095, 7), 0);              // edge past the coordinate range
        send_box(mk_box(0, 4090, 4095, 4095, 7), 1);

        // zero threshold: disjoint boxes are suppressed too
        write_threshold(16'd0);
        send_box(mk_box(0, 0, 1, 1, 3), 0);
        send_box(mk_box(3000, 3000, 1, 1, 2), 0);
        send_box(mk_box(100, 1000, 9, 9, 3), 1);

        // full-scale threshold: only identical boxes meet it
        write_threshold(16'hFFFF);
        send_box(mk_box(50, 50, 99, 99, 100), 0);
        send_box(mk_box(50, 50, 99, 99, 100), 0);
        send_box(mk_box(51, 50, 99, 99, 200), 0);
        send_box(mk_box(50, 51, 99, 99, 300), 1);

        // random part in three phases of idling
        items_sent = 0;
        big_done = 0;
        for (phase = 0; phase < 3; phase++) begin
            write_threshold(thr_list[phase]);
            send_idle_pct  = (phase == 0) ? 24 : (phase == 1) ? 50 : 0;
            recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 24 : 0;
            if (phase == 0) hold_go = 1;   // block fills while results wait
            while (items_sent < RANDOM_ITEMS * (phase + 1) / 3) begin
                if (phase == 1 && big_done < 2) begin
                    // store overflow: once on the closing item alone, once on several
                    random_set(big_done == 0 ? MAX_BOXES + 1 : MAX_BOXES + 3);
                    big_done++;
                end else begin
                    n = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
                    random_set(n);
                end
            end
        end

        wait_idle();
        repeat (100) @(negedge aclk);
        if (fail_count == 0 && kept_pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
sv/gbs_pkg.sv
sv/gbs_front.sv
sv/gbs_iou.sv
sv/gbs_core.sv
sv/greedy_box_suppression.sv
bench/gbs_checker.sv
bench/testbench.sv
